>>> hdl/c8x_pkg.sv
// c8x_pkg: shared types, constants and a helper function for the chip8 execute core
// no dependencies
package c8x_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned SpDw = $clog2(StackDepth + 1);
  localparam int unsigned SpIw = $clog2(StackDepth);
  localparam logic [11:0] StartReset = 12'd512;
  localparam logic [7:0] SpriteHeight = 8'd5;

  localparam logic [1:0] DispNone = 2'd0;
  localparam logic [1:0] DispClear = 2'd1;
  localparam logic [1:0] DispDraw = 2'd2;

  // command from controller to datapath
  typedef enum logic [2:0] {
    CmdNone  = 3'd0,
    CmdExec  = 3'd1,
    CmdWrite = 3'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] wr_idx;
  } ctl_t;

  typedef struct packed {
    logic [4:0] wr_cnt;
  } sts_t;

  typedef struct packed {
    logic [15:0] instr_word;
    logic [15:0] key_state;
    logic [3:0]  key_code;
    logic [7:0]  random_value;
    logic [63:0] fill_low;
    logic [63:0] fill_high;
    logic        timer_tick;
  } in_t;

  typedef struct packed {
    logic        mem_write_valid;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic        last_of_run;
    logic [15:0] program_counter;
    logic [15:0] index_value;
    logic        sound_on;
    logic [1:0]  display_request;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [3:0]  draw_rows;
    logic        stack_fault;
  } out_t;

  // bcd digits of a byte: hundreds via small compares, tens and units by arithmetic
  function automatic logic [11:0] bcd8(input logic [7:0] v);
    logic [3:0] h;
    logic [7:0] r;
    logic [3:0] t;
    h = (v >= 8'd200) ? 4'd2 : (v >= 8'd100) ? 4'd1 : 4'd0;
    r = v - 8'(h * 8'd100);
    // tens by reciprocal multiply, exact for r below 100
    t = 4'(({8'd0, r} * 16'd205) >> 11);
    return {h, t, 4'(r - 8'(t * 8'd10))};
  endfunction

endpackage

>>> hdl/c8x_if.sv
// c8x_if: valid/ready channel interface
// no dependencies
interface c8x_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/c8x_ctrl.sv
// c8x_ctrl: one-hot controller sequencing execute and memory write beats
// depends on c8x_pkg
module c8x_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          out_last_o,
  output c8x_pkg::ctl_t ctl_o,
  input  c8x_pkg::sts_t sts_i
);
  import c8x_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StEmit = 3'b010,
    StWr   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [4:0] idx_q, idx_d;

  // beats of the current item; zero writes gives one beat
  logic [4:0] beats;
  assign beats = (sts_i.wr_cnt == 5'd0) ? 5'd1 : sts_i.wr_cnt;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign out_last_o  = (idx_q + 5'd1 == beats);

  // next state
  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    ctl_o.cmd = CmdNone;
    ctl_o.wr_idx = idx_q[3:0];
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ctl_o.cmd = CmdExec;
          idx_d = 5'd0;
          state_d = StWr;
        end
      end
      StWr: begin
        ctl_o.cmd = CmdWrite;
        state_d = StEmit;
      end
      StEmit: begin
        if (out_ready_i) begin
          if (out_last_o) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + 5'd1;
            state_d = StWr;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= 5'd0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
    end
  end
endmodule

>>> hdl/c8x_dp.sv
// c8x_dp: register file, stack, timers and execute datapath
// depends on c8x_pkg
module c8x_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [11:0]   cfg_wdata_i,
  input  c8x_pkg::in_t  in_i,
  input  c8x_pkg::ctl_t ctl_i,
  output c8x_pkg::sts_t sts_o,
  input  logic          last_i,
  output c8x_pkg::out_t out_o
);
  import c8x_pkg::*;

  logic [7:0]  v_q [16];
  logic [7:0]  v_d [16];
  logic [15:0] i_q, i_d, pc_q, pc_d;
  logic [15:0] stk_q [StackDepth];
  logic [SpDw-1:0] sp_q, sp_d;
  logic [7:0]  dt_q, dt_d, st_q, st_d;
  logic [4:0]  wcnt_q, wcnt_d;
  logic        wbcd_q, wbcd_d, fault_q, fault_d;
  logic [11:0] bcd_q, bcd_d;
  logic [15:0] wbase_q, wbase_d;
  logic [1:0]  disp_q, disp_d;
  logic [7:0]  dx_q, dx_d, dy_q, dy_d;
  logic [3:0]  dn_q, dn_d;
  logic        push;
  logic [15:0] push_val;
  logic [7:0]  wdat_q;
  logic [15:0] wadr_q;

  logic [15:0] op;
  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy;
  logic [8:0]  add9;
  logic [15:0] pc2;
  logic [15:0] fill [2];
  logic [127:0] fill_all;

  assign op = in_i.instr_word;
  assign x = op[11:8];
  assign y = op[7:4];
  assign n = op[3:0];
  assign kk = op[7:0];
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign pc2 = pc_q + 16'd2;
  assign fill_all = {in_i.fill_high, in_i.fill_low};
  assign sts_o.wr_cnt = wcnt_q;

  // execute one instruction; a config write reloads the pc
  always_comb begin
    logic [7:0] r;
    logic down;
    v_d = v_q; i_d = i_q; pc_d = pc_q; sp_d = sp_q; dt_d = dt_q; st_d = st_q;
    wcnt_d = wcnt_q; wbcd_d = wbcd_q; bcd_d = bcd_q; wbase_d = wbase_q;
    fault_d = fault_q; disp_d = disp_q; dx_d = dx_q; dy_d = dy_q; dn_d = dn_q;
    push = 1'b0; push_val = pc2; r = 8'd0; down = 1'b0; add9 = 9'd0;
    if (ctl_i.cmd == CmdExec) begin
      pc_d = pc2; wcnt_d = 5'd0; wbcd_d = 1'b0; fault_d = 1'b0;
      disp_d = DispNone; dx_d = 8'd0; dy_d = 8'd0; dn_d = 4'd0;
      wbase_d = i_q; bcd_d = bcd8(vx);
      if (op == 16'h00E0) begin
        disp_d = DispClear;
      end else if (op == 16'h00EE) begin
        if (sp_q == '0) fault_d = 1'b1;
        else begin
          sp_d = sp_q - 1'b1;
          pc_d = stk_q[SpIw'(sp_q - 1'b1)];
        end
      end else begin
        case (op[15:12])
          4'h1: pc_d = {4'd0, op[11:0]};
          4'h2: begin
            if (sp_q >= SpDw'(StackDepth)) fault_d = 1'b1;
            else begin
              push = 1'b1; sp_d = sp_q + 1'b1; pc_d = {4'd0, op[11:0]};
            end
          end
          4'h3: if (vx == kk) pc_d = pc2 + 16'd2;
          4'h4: if (vx != kk) pc_d = pc2 + 16'd2;
          4'h5: if (vx == vy) pc_d = pc2 + 16'd2;
          4'h6: v_d[x] = kk;
          4'h7: v_d[x] = vx + kk;
          4'h8: begin
            case (n)
              4'h0: v_d[x] = vy;
              4'h1: v_d[x] = vx | vy;
              4'h2: v_d[x] = vx & vy;
              4'h3: v_d[x] = vx ^ vy;
              4'h4: begin
                add9 = {1'b0, vx} + {1'b0, vy};
                v_d[x] = add9[7:0]; v_d[15] = {7'd0, add9[8]};
              end
              4'h5: begin v_d[x] = vx - vy; v_d[15] = {7'd0, vx > vy}; end
              4'h6: begin v_d[x] = vx >> 1; v_d[15] = {7'd0, vx[0]}; end
              4'h7: begin v_d[x] = vy - vx; v_d[15] = {7'd0, vy > vx}; end
              4'hE: begin v_d[x] = vx << 1; v_d[15] = {7'd0, vx[7]}; end
              default: ;
            endcase
          end
          4'h9: if (vx != vy) pc_d = pc2 + 16'd2;
          4'hA: i_d = {4'd0, op[11:0]};
          4'hB: pc_d = {4'd0, op[11:0]} + {8'd0, v_q[0]};
          4'hC: begin
            r = (in_i.random_value == 8'd255) ? 8'd0 : in_i.random_value;
            v_d[x] = r & kk;
          end
          4'hD: begin disp_d = DispDraw; dx_d = vx; dy_d = vy; dn_d = n; end
          4'hE: begin
            down = (vx[7:4] == 4'd0) && in_i.key_state[vx[3:0]];
            if ((kk == 8'h9E && down) || (kk == 8'hA1 && !down)) pc_d = pc2 + 16'd2;
          end
          4'hF: begin
            case (kk)
              8'h07: v_d[x] = dt_q;
              8'h0A: v_d[x] = {4'd0, in_i.key_code};
              8'h15: dt_d = vx;
              8'h18: st_d = vx;
              8'h1E: i_d = i_q + {8'd0, vx};
              8'h29: i_d = 16'(vx * SpriteHeight);
              8'h33: begin wcnt_d = 5'd3; wbcd_d = 1'b1; end
              8'h55: wcnt_d = {1'b0, x} + 5'd1;
              8'h65: begin
                for (int k = 0; k < 16; k++)
                  if (k <= x) v_d[k] = fill_all[8*k +: 8];
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      // timer tick after execution
      if (in_i.timer_tick) begin
        if (dt_d != 8'd0) dt_d = dt_d - 8'd1;
        if (st_d != 8'd0) st_d = st_d - 8'd1;
      end
    end
    if (cfg_we_i) pc_d = {4'd0, cfg_wdata_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) v_q[k] <= 8'd0;
      i_q <= '0; pc_q <= {4'd0, StartReset}; sp_q <= '0; dt_q <= '0; st_q <= '0;
      wcnt_q <= '0; fault_q <= 1'b0; disp_q <= DispNone;
    end else begin
      v_q <= v_d; i_q <= i_d; pc_q <= pc_d; sp_q <= sp_d; dt_q <= dt_d; st_q <= st_d;
      wcnt_q <= wcnt_d; fault_q <= fault_d; disp_q <= disp_d;
    end
  end

  // payload-only registers
  always_ff @(posedge clk_i) begin
    wbcd_q <= wbcd_d; bcd_q <= bcd_d; wbase_q <= wbase_d;
    dx_q <= dx_d; dy_q <= dy_d; dn_q <= dn_d;
    if (push) stk_q[SpIw'(sp_q)] <= push_val;
    if (ctl_i.cmd == CmdWrite) begin
      wadr_q <= wbase_q + {12'd0, ctl_i.wr_idx};
      case (ctl_i.wr_idx[1:0])
        2'd0: fill[0] <= {8'd0, 4'd0, bcd_q[11:8]};
        2'd1: fill[0] <= {8'd0, 4'd0, bcd_q[7:4]};
        default: fill[0] <= {8'd0, 4'd0, bcd_q[3:0]};
      endcase
      fill[1] <= {8'd0, v_q[ctl_i.wr_idx]};
    end
  end

  assign wdat_q = wbcd_q ? fill[0][7:0] : fill[1][7:0];

  // result beat
  always_comb begin
    out_o.mem_write_valid = (wcnt_q != 5'd0);
    out_o.mem_addr = out_o.mem_write_valid ? wadr_q : 16'd0;
    out_o.mem_data = out_o.mem_write_valid ? wdat_q : 8'd0;
    out_o.last_of_run = last_i;
    out_o.program_counter = pc_q;
    out_o.index_value = i_q;
    out_o.sound_on = (st_q != 8'd0);
    out_o.display_request = disp_q;
    out_o.draw_x = dx_q;
    out_o.draw_y = dy_q;
    out_o.draw_rows = dn_q;
    out_o.stack_fault = fault_q;
  end
endmodule

>>> hdl/chip8_instruction_execute_core.sv
// chip8_instruction_execute_core: one CHIP-8 instruction per accepted beat
// each accepted beat passes through the write state, then the emit state, to a result beat;
// further beats of a write run repeat write then emit, and emit waits on out ready;
// no new instruction is accepted until the last beat of the run is taken; reset
// async active low, clears registers, timers, stack depth, pc to start_address 512
// depends on c8x_pkg, c8x_if, c8x_ctrl, c8x_dp
module chip8_instruction_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  c8x_if.sink         in_if,
  c8x_if.source       out_if
);
  import c8x_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic last;
  out_t res;

  c8x_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_last_o(last), .ctl_o(ctl), .sts_i(sts)
  );

  c8x_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_i(in_if.data), .ctl_i(ctl), .sts_o(sts), .last_i(last), .out_o(res)
  );

  assign out_if.data = res;

  // no accept while a result is pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid)) else $error("accept overlaps result");
  // a write run never exceeds sixteen beats
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.wr_cnt <= 5'd16) else $error("write count out of range");
  // after a last beat the core goes idle
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && out_if.data.last_of_run |=> in_if.ready)
    else $error("not idle after last beat");
endmodule

>>> tb/sv/tb_chip8_instruction_execute_core.sv
// tb_chip8_instruction_execute_core: self-checking testbench for the chip8 execute core
// drives instruction beats with random idling, predicts result beats, compares them
// depends on c8x_pkg, c8x_if, chip8_instruction_execute_core
`timescale 1ns / 1ps
module tb_chip8_instruction_execute_core;
  import c8x_pkg::*;

  localparam int unsigned FlushCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;

  c8x_if #(.T(in_t)) in_ch ();
  c8x_if #(.T(out_t)) out_ch ();

  chip8_instruction_execute_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  v_reg [16];
  logic [15:0] i_reg;
  logic [15:0] pc;
  logic [15:0] call_stack [StackDepth];
  int unsigned depth;
  logic [7:0]  delay_t;
  logic [7:0]  sound_t;

  in_t  instr_q [$];
  out_t beat_q [$];
  int   n_errors = 0;
  int   n_beats = 0;
  int   n_writes = 0;
  int   n_faults = 0;
  bit   quiet = 1'b0;
  bit   src_pause = 1'b0;
  int   sink_hold = 0;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    n_errors++;
    $display("mismatch beat %0d %s: got %h want %h", n_beats, what, got, want);
  endtask

  function automatic void reset_model(input logic [11:0] start);
    for (int r = 0; r < 16; r++) v_reg[r] = '0;
    i_reg = '0;
    pc = {4'd0, start};
    depth = 0;
    delay_t = '0;
    sound_t = '0;
  endfunction

  // execute one instruction and push its result beats
  function automatic void run_instr(input in_t it);
    logic [15:0] op;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  kk;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [8:0]  sum;
    logic [15:0] wa [16];
    logic [7:0]  wd [16];
    int          nw;
    logic [1:0]  disp;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [3:0]  rows;
    logic        fault;
    logic        down;
    out_t        o;
    op = it.instr_word;
    x = op[11:8];
    y = op[7:4];
    kk = op[7:0];
    vx = v_reg[x];
    vy = v_reg[y];
    nw = 0;
    disp = DispNone;
    dx = '0;
    dy = '0;
    rows = '0;
    fault = 1'b0;
    pc = pc + 16'd2;
    if (op == 16'h00E0) begin
      disp = DispClear;
    end else if (op == 16'h00EE) begin
      if (depth == 0) fault = 1'b1;
      else begin
        depth--;
        pc = call_stack[depth];
      end
    end else begin
      case (op[15:12])
        4'h1: pc = {4'd0, op[11:0]};
        4'h2: begin
          if (depth >= StackDepth) fault = 1'b1;
          else begin
            call_stack[depth] = pc;
            depth++;
            pc = {4'd0, op[11:0]};
          end
        end
        4'h3: if (vx == kk) pc = pc + 16'd2;
        4'h4: if (vx != kk) pc = pc + 16'd2;
        4'h5: if (vx == vy) pc = pc + 16'd2;
        4'h6: v_reg[x] = kk;
        4'h7: v_reg[x] = vx + kk;
        4'h8: begin
          case (op[3:0])
            4'h0: v_reg[x] = vy;
            4'h1: v_reg[x] = vx | vy;
            4'h2: v_reg[x] = vx & vy;
            4'h3: v_reg[x] = vx ^ vy;
            4'h4: begin
              sum = {1'b0, vx} + {1'b0, vy};
              v_reg[x] = sum[7:0];
              v_reg[15] = {7'd0, sum[8]};
            end
            4'h5: begin
              v_reg[x] = vx - vy;
              v_reg[15] = {7'd0, vx > vy};
            end
            4'h6: begin
              v_reg[x] = vx >> 1;
              v_reg[15] = {7'd0, vx[0]};
            end
            4'h7: begin
              v_reg[x] = vy - vx;
              v_reg[15] = {7'd0, vy > vx};
            end
            4'hE: begin
              v_reg[x] = vx << 1;
              v_reg[15] = {7'd0, vx[7]};
            end
            default: ;
          endcase
        end
        4'h9: if (vx != vy) pc = pc + 16'd2;
        4'hA: i_reg = {4'd0, op[11:0]};
        4'hB: pc = {4'd0, op[11:0]} + {8'd0, v_reg[0]};
        4'hC: v_reg[x] = 8'((it.random_value % 255) & kk);
        4'hD: begin
          disp = DispDraw;
          dx = vx;
          dy = vy;
          rows = op[3:0];
        end
        4'hE: begin
          down = (vx < 16) && it.key_state[vx[3:0]];
          if ((kk == 8'h9E && down) || (kk == 8'hA1 && !down)) pc = pc + 16'd2;
        end
        4'hF: begin
          case (kk)
            8'h07: v_reg[x] = delay_t;
            8'h0A: v_reg[x] = {4'd0, it.key_code};
            8'h15: delay_t = vx;
            8'h18: sound_t = vx;
            8'h1E: i_reg = i_reg + {8'd0, vx};
            8'h29: i_reg = 16'(vx * 5);
            8'h33: begin
              wa[0] = i_reg; wd[0] = vx / 100;
              wa[1] = i_reg + 16'd1; wd[1] = (vx / 10) % 10;
              wa[2] = i_reg + 16'd2; wd[2] = vx % 10;
              nw = 3;
            end
            8'h55: begin
              for (int r = 0; r <= x; r++) begin
                wa[r] = i_reg + 16'(r);
                wd[r] = v_reg[r];
              end
              nw = x + 1;
            end
            8'h65: begin
              for (int r = 0; r <= x; r++)
                v_reg[r] = (r < 8) ? it.fill_low[8*r +: 8] : it.fill_high[8*(r-8) +: 8];
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    if (it.timer_tick) begin
      if (delay_t != 0) delay_t--;
      if (sound_t != 0) sound_t--;
    end
    for (int k = 0; k < ((nw > 0) ? nw : 1); k++) begin
      o.mem_write_valid = nw > 0;
      o.mem_addr = (nw > 0) ? wa[k] : 16'd0;
      o.mem_data = (nw > 0) ? wd[k] : 8'd0;
      o.last_of_run = (k == ((nw > 0) ? nw : 1) - 1);
      o.program_counter = pc;
      o.index_value = i_reg;
      o.sound_on = sound_t != 0;
      o.display_request = disp;
      o.draw_x = dx;
      o.draw_y = dy;
      o.draw_rows = rows;
      o.stack_fault = fault;
      beat_q.push_back(o);
    end
  endfunction

  // driver: offers queued instruction beats with random gaps
  int gap = 0;
  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) run_instr(in_ch.data);
    if (!(in_ch.valid && !in_ch.ready)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_ch.valid <= 1'b0;
      end else if (instr_q.size() > 0 && !src_pause && rst_ni) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= instr_q.pop_front();
        if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 11);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: compares result beats with the oldest prediction and drives ready with random stalls
  int sgap = 0;
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      n_beats++;
      if (beat_q.size() == 0) begin
        report("unexpected beat", 16'd0, 16'd0);
      end else begin
        out_t w;
        out_t g;
        w = beat_q.pop_front();
        g = out_ch.data;
        if (g.mem_write_valid) n_writes++;
        if (g.stack_fault) n_faults++;
        if (g.mem_write_valid != w.mem_write_valid)
          report("mem_write_valid", g.mem_write_valid, w.mem_write_valid);
        if (g.mem_addr != w.mem_addr) report("mem_addr", g.mem_addr, w.mem_addr);
        if (g.mem_data != w.mem_data) report("mem_data", g.mem_data, w.mem_data);
        if (g.last_of_run != w.last_of_run)
          report("last_of_run", g.last_of_run, w.last_of_run);
        if (g.program_counter != w.program_counter)
          report("program_counter", g.program_counter, w.program_counter);
        if (g.index_value != w.index_value)
          report("index_value", g.index_value, w.index_value);
        if (g.sound_on != w.sound_on) report("sound_on", g.sound_on, w.sound_on);
        if (g.display_request != w.display_request)
          report("display_request", g.display_request, w.display_request);
        if (g.draw_x != w.draw_x) report("draw_x", g.draw_x, w.draw_x);
        if (g.draw_y != w.draw_y) report("draw_y", g.draw_y, w.draw_y);
        if (g.draw_rows != w.draw_rows) report("draw_rows", g.draw_rows, w.draw_rows);
        if (g.stack_fault != w.stack_fault)
          report("stack_fault", g.stack_fault, w.stack_fault);
      end
    end
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (sgap > 0) begin
      sgap <= sgap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) sgap <= $urandom_range(1, 11);
    end
  end

  function automatic in_t mk(input logic [15:0] op);
    in_t it;
    it.instr_word = op;
    it.key_state = 16'($urandom);
    it.key_code = 4'($urandom);
    it.random_value = 8'($urandom_range(0, 254));
    it.fill_low = {$urandom, $urandom};
    it.fill_high = {$urandom, $urandom};
    it.timer_tick = 1'($urandom);
    return it;
  endfunction

  // random instruction weighted toward useful ones; plan_depth tracks stack use but does not limit it
  int unsigned plan_depth = 0;
  function automatic logic [15:0] rand_op();
    logic [15:0] op;
    int sel;
    sel = $urandom_range(0, 19);
    op = 16'($urandom);
    case (sel)
      0: op = 16'h00E0;
      1: op = 16'h00EE;
      2: op[15:12] = 4'h2;
      3, 4: op[15:12] = 4'h6;
      5: op[15:12] = 4'h8;
      6: op = {4'h8, op[11:4], 4'($urandom_range(0, 7))};
      7: op = {4'h8, op[11:4], 4'hE};
      8: op = {4'hF, op[11:8], 8'h55};
      9: op = {4'hF, op[11:8], 8'h65};
      10: op = {4'hF, op[11:8], 8'h33};
      11: begin
        case ($urandom_range(0, 6))
          0: op[7:0] = 8'h07;
          1: op[7:0] = 8'h0A;
          2: op[7:0] = 8'h15;
          3: op[7:0] = 8'h18;
          4: op[7:0] = 8'h1E;
          default: op[7:0] = 8'h29;
        endcase
        op[15:12] = 4'hF;
      end
      12: op = {4'hE, op[11:8], ($urandom_range(0, 1) ? 8'h9E : 8'hA1)};
      default: ;
    endcase
    if (op == 16'h00EE && plan_depth > 0) plan_depth--;
    if (op[15:12] == 4'h2 && plan_depth < StackDepth) plan_depth++;
    return op;
  endfunction

  task automatic wait_drained();
    while (instr_q.size() > 0 || in_ch.valid || beat_q.size() > 0) @(posedge clk_i);
    repeat (FlushCycles) @(posedge clk_i);
  endtask

  // a start address write reloads only the program counter
  task automatic set_start(input logic [11:0] addr);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pc = {4'd0, addr};
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    reset_model(StartReset);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: clear, empty return, alu flags with x = F, bcd, stores, loads, draw, random, skips, jump
    instr_q.push_back(mk(16'h00E0));
    instr_q.push_back(mk(16'h00EE));
    instr_q.push_back(mk(16'h6FFF));
    instr_q.push_back(mk(16'h61FF));
    instr_q.push_back(mk(16'h8F14));
    instr_q.push_back(mk(16'h6F81));
    instr_q.push_back(mk(16'h8FFE));
    instr_q.push_back(mk(16'h8F16));
    instr_q.push_back(mk(16'h8F15));
    instr_q.push_back(mk(16'h8F17));
    instr_q.push_back(mk(16'hF133));
    instr_q.push_back(mk(16'hAFFF));
    instr_q.push_back(mk(16'hFF55));
    instr_q.push_back(mk(16'hFF65));
    instr_q.push_back(mk(16'hDEF0));
    instr_q.push_back(mk(16'hC2FF));
    instr_q.push_back(mk(16'h53A5));
    instr_q.push_back(mk(16'h9127));
    instr_q.push_back(mk(16'hE19E));
    instr_q.push_back(mk(16'hE2A1));
    instr_q.push_back(mk(16'h8128));
    instr_q.push_back(mk(16'hB0FF));
    instr_q.push_back(mk(16'h0123));
    instr_q.push_back(mk(16'hF318));
    wait_drained();

    // stack overflow then underflow, start address at its top extreme
    set_start(12'hFFF);
    for (int k = 0; k < StackDepth + 2; k++) instr_q.push_back(mk(16'h2FFE));
    for (int k = 0; k < StackDepth + 2; k++) instr_q.push_back(mk(16'h00EE));
    wait_drained();

    // random phases over several start addresses; long sink stall in the first, source pause in the second
    for (int ph = 0; ph < 4; ph++) begin
      set_start(ph == 0 ? 12'h000 : ph == 1 ? StartReset : 12'($urandom));
      plan_depth = 0;
      if (ph == 3) quiet = 1'b1;
      for (int k = 0; k < 120; k++) instr_q.push_back(mk(rand_op()));
      if (ph == 0) begin
        repeat (5) @(posedge clk_i);
        sink_hold = 300;
      end
      if (ph == 1) begin
        while (instr_q.size() > 60) @(posedge clk_i);
        src_pause = 1'b1;
        while (in_ch.valid || beat_q.size() > 0) @(posedge clk_i);
        src_pause = 1'b0;
      end
      wait_drained();
    end

    $display("covered %0d result beats, %0d memory writes, %0d stack faults",
             n_beats, n_writes, n_faults);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
